// ===== hw/rtl/sle_pkg.sv =====
// Package for the scancode line editor: scancodes, action codes, result struct, key tables.
package sle_pkg;

    // Set-1 scancodes (make codes; release adds SC_RELEASE)
    localparam logic [7:0] SC_LSHIFT  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_CAPS    = 8'h3A;
    localparam logic [7:0] SC_CTRL    = 8'h1D;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_BKSP    = 8'h0E;
    localparam logic [7:0] SC_ENTER   = 8'h1C;
    localparam logic [7:0] SC_KEY_L   = 8'h26;
    localparam logic [7:0] SC_F1      = 8'h3B;
    localparam logic [7:0] SC_F3      = 8'h3D;
    localparam logic [7:0] SC_RELEASE = 8'h80;

    localparam logic [6:0] CH_NEWLINE = 7'h0A;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    localparam logic MODE_SCANCODE = 1'b0;
    localparam logic MODE_TAKEN    = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_STORE = 3'd1,
        ACT_ERASE = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_TERM  = 3'd4
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [6:0] character;
        logic [6:0] position;
        logic       line_ready;
        logic [1:0] terminal_select;
        logic [7:0] char_count;
    } t_result;

    function automatic logic is_letter(input logic [5:0] s);
        return (s >= 6'h10 && s <= 6'h19) || (s >= 6'h1E && s <= 6'h26) ||
               (s >= 6'h2C && s <= 6'h32);
    endfunction

    function automatic logic [6:0] low_char(input logic [5:0] s);
        logic [6:0] c;
        case (s)
            6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;  6'h05: c = 7'h34;
            6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;  6'h09: c = 7'h38;
            6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;  6'h0D: c = 7'h3D;
            6'h10: c = 7'h71;  6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;
            6'h14: c = 7'h74;  6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;
            6'h18: c = 7'h6F;  6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;
            6'h1E: c = 7'h61;  6'h1F: c = 7'h73;  6'h20: c = 7'h64;  6'h21: c = 7'h66;
            6'h22: c = 7'h67;  6'h23: c = 7'h68;  6'h24: c = 7'h6A;  6'h25: c = 7'h6B;
            6'h26: c = 7'h6C;  6'h27: c = 7'h3B;  6'h28: c = 7'h27;  6'h29: c = 7'h60;
            6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;  6'h2E: c = 7'h63;
            6'h2F: c = 7'h76;  6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;
            6'h33: c = 7'h2C;  6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h37: c = 7'h2A;
            6'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] up_char(input logic [5:0] s);
        logic [6:0] c;
        case (s)
            6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
            6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
            6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
            6'h10: c = 7'h51;  6'h11: c = 7'h57;  6'h12: c = 7'h45;  6'h13: c = 7'h52;
            6'h14: c = 7'h54;  6'h15: c = 7'h59;  6'h16: c = 7'h55;  6'h17: c = 7'h49;
            6'h18: c = 7'h4F;  6'h19: c = 7'h50;  6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;
            6'h1E: c = 7'h41;  6'h1F: c = 7'h53;  6'h20: c = 7'h44;  6'h21: c = 7'h46;
            6'h22: c = 7'h47;  6'h23: c = 7'h48;  6'h24: c = 7'h4A;  6'h25: c = 7'h4B;
            6'h26: c = 7'h4C;  6'h27: c = 7'h3A;  6'h28: c = 7'h22;  6'h29: c = 7'h7E;
            6'h2B: c = 7'h7C;  6'h2C: c = 7'h5A;  6'h2D: c = 7'h58;  6'h2E: c = 7'h43;
            6'h2F: c = 7'h56;  6'h30: c = 7'h42;  6'h31: c = 7'h4E;  6'h32: c = 7'h4D;
            6'h33: c = 7'h3C;  6'h34: c = 7'h3E;  6'h35: c = 7'h3F;  6'h37: c = 7'h2A;
            6'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/sle_keymap.sv =====
// Key map: scancode plus shift/caps flags to ASCII character.
module sle_keymap (
    input  logic [7:0] i_scancode,
    input  logic       i_shift,
    input  logic       i_caps,
    output logic [6:0] o_character,
    output logic       o_printable
);

    logic [6:0] w_low;
    logic [6:0] w_up;
    logic       w_letter;
    logic       w_in_table;

    assign w_in_table = (i_scancode[7:6] == 2'b00);
    assign w_low      = sle_pkg::low_char(i_scancode[5:0]);
    assign w_up       = sle_pkg::up_char(i_scancode[5:0]);
    assign w_letter   = sle_pkg::is_letter(i_scancode[5:0]);

    always_comb begin
        if (i_shift && i_caps) begin
            // caps cancels shift on letters only
            o_character = w_letter ? w_low : w_up;
        end else if ((i_caps && w_letter) || i_shift) begin
            o_character = w_up;
        end else begin
            o_character = w_low;
        end
    end

    assign o_printable = w_in_table && (w_low != 7'h00);

endmodule

// ===== hw/rtl/sle_editor.sv =====
// Editor core: modifier flags, line count and per-key action decode.
module sle_editor #(
    parameter int LINE_CAPACITY = 127
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_mode,
    input  logic [7:0]      i_scancode,
    output sle_pkg::t_result o_result
);

    localparam int CapW = $clog2(LINE_CAPACITY + 1);
    localparam int CmpW = (CapW > 8) ? CapW : 8;
    localparam logic [CmpW-1:0] CapVal = CmpW'(LINE_CAPACITY);

    logic       r_shift, n_shift;
    logic       r_caps,  n_caps;
    logic       r_ctrl,  n_ctrl;
    logic       r_alt,   n_alt;
    logic [7:0] r_count, n_count;

    logic [6:0]      w_char;
    logic            w_printable;
    logic [CmpW-1:0] w_count_ext;
    logic [7:0]      w_count_inc;
    logic [7:0]      w_count_dec;
    logic [7:0]      w_term;

    sle_keymap u_keymap (
        .i_scancode  (i_scancode),
        .i_shift     (r_shift),
        .i_caps      (r_caps),
        .o_character (w_char),
        .o_printable (w_printable)
    );

    assign w_count_ext = CmpW'(r_count);
    assign w_count_inc = (r_count == sle_pkg::COUNT_MAX) ? r_count : r_count + 8'd1;
    assign w_count_dec = r_count - 8'd1;
    assign w_term      = i_scancode - sle_pkg::SC_F1;

    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        n_ctrl  = r_ctrl;
        n_alt   = r_alt;
        n_count = r_count;
        o_result = '0;
        o_result.action = sle_pkg::ACT_NONE;

        if (i_mode == sle_pkg::MODE_TAKEN) begin
            n_count = 8'd0;
        end else if (i_scancode == sle_pkg::SC_LSHIFT || i_scancode == sle_pkg::SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (i_scancode == (sle_pkg::SC_LSHIFT | sle_pkg::SC_RELEASE) ||
                     i_scancode == (sle_pkg::SC_RSHIFT | sle_pkg::SC_RELEASE)) begin
            n_shift = 1'b0;
        end else if (i_scancode == sle_pkg::SC_CAPS) begin
            n_caps = ~r_caps;
        end else if (i_scancode == sle_pkg::SC_CTRL) begin
            n_ctrl = 1'b1;
        end else if (i_scancode == (sle_pkg::SC_CTRL | sle_pkg::SC_RELEASE)) begin
            n_ctrl = 1'b0;
        end else if (i_scancode == sle_pkg::SC_ALT) begin
            n_alt = 1'b1;
        end else if (i_scancode == (sle_pkg::SC_ALT | sle_pkg::SC_RELEASE)) begin
            n_alt = 1'b0;
        end else if (i_scancode == sle_pkg::SC_BKSP) begin
            if (r_count != 8'd0) begin
                n_count           = w_count_dec;
                o_result.action   = sle_pkg::ACT_ERASE;
                o_result.position = w_count_dec[6:0];
            end
        end else if (i_scancode[7] == 1'b0) begin
            // F-keys have no table entry, so terminal switch never collides with typing
            if (r_alt && i_scancode >= sle_pkg::SC_F1 && i_scancode <= sle_pkg::SC_F3) begin
                o_result.action          = sle_pkg::ACT_TERM;
                o_result.terminal_select = w_term[1:0];
            end
            if (r_ctrl) begin
                if (i_scancode == sle_pkg::SC_KEY_L) begin
                    o_result.action = sle_pkg::ACT_CLEAR;
                end
            end else if (i_scancode == sle_pkg::SC_ENTER) begin
                o_result.line_ready = 1'b1;
                // one slot past capacity is kept for the newline
                if (w_count_ext <= CapVal) begin
                    o_result.action    = sle_pkg::ACT_STORE;
                    o_result.character = sle_pkg::CH_NEWLINE;
                    o_result.position  = r_count[6:0];
                    n_count            = w_count_inc;
                end
            end else if (w_printable) begin
                if (w_count_ext < CapVal) begin
                    o_result.action    = sle_pkg::ACT_STORE;
                    o_result.character = w_char;
                    o_result.position  = r_count[6:0];
                    n_count            = w_count_inc;
                end
            end
        end

        o_result.char_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_ctrl  <= 1'b0;
            r_alt   <= 1'b0;
            r_count <= 8'd0;
        end else if (i_step) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_ctrl  <= n_ctrl;
            r_alt   <= n_alt;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/scancode_line_editor_core.sv =====
// Top level of the scancode line editor: input register, editor decode, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per key event:
//   i_mode = 0 with a set-1 scancode byte, or i_mode = 1 to tell the block the reader
//   took the line (the character count returns to zero, scancode ignored).
//   Output channel (o_out_valid / i_out_stall) carries exactly one result transaction per
//   input transaction, in order: action, character, line position, line-ready pulse,
//   terminal number and the character count after the key.
//   An accepted input loads the input register at the accepting edge; decode and flag
//   update then feed the result register, which drives the output channel.
//   Throughput: one transaction per cycle unless i_out_stall holds it; the decode is a single
//   pass of shallow logic against the flag/count registers, so nothing else limits it.
//   Stall: when the result register holds an untaken result and i_out_stall is high,
//   a full input register holds and o_in_stall rises (an empty one still takes one
//   transaction); both registers move on as soon as the receiver takes the result.
//   Reset (synchronous, active low): both stage valids clear, shift/caps/ctrl/alt flags
//   clear and the line count goes to zero. The block is ready the cycle after reset.
module scancode_line_editor_core #(
    parameter int LINE_CAPACITY = 127
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_scancode,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_action,
    output logic [6:0] o_character,
    output logic [6:0] o_position,
    output logic       o_line_ready,
    output logic [1:0] o_terminal_select,
    output logic [7:0] o_char_count
);

    // input stage
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_scancode;

    // result stage
    logic             r_out_valid;
    sle_pkg::t_result r_out;

    logic             w_out_free;
    logic             w_step;
    logic             w_in_take;
    sle_pkg::t_result w_result;

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    // input register can load when empty or moving on this cycle
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    sle_editor #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_editor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_mode     (r_in_mode),
        .i_scancode (r_in_scancode),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode     <= i_mode;
            r_in_scancode <= i_scancode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_out.action;
    assign o_character       = r_out.character;
    assign o_position        = r_out.position;
    assign o_line_ready      = r_out.line_ready;
    assign o_terminal_select = r_out.terminal_select;
    assign o_char_count      = r_out.char_count;

endmodule

// ===== hw/rtl/sle_checker.sv =====
// Port-level checker for the scancode line editor, bound to the top level.
module sle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_mode,
    input logic [7:0] i_scancode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_action,
    input logic [6:0] o_character,
    input logic [6:0] o_position,
    input logic       o_line_ready,
    input logic [1:0] o_terminal_select,
    input logic [7:0] o_char_count
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_action) && $stable(o_character) &&
            $stable(o_position) && $stable(o_char_count))
        else $error("output transaction changed under stall");

    // line-ready comes only with a stored newline or a dropped one
    a_ready_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_ready |->
            (o_action == sle_pkg::ACT_STORE || o_action == sle_pkg::ACT_NONE))
        else $error("line_ready with unexpected action");

    // erase reports the slot that the count now points at
    a_erase_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == sle_pkg::ACT_ERASE |-> o_position == o_char_count[6:0])
        else $error("erase position does not match count");

    // a store always leaves a nonzero count
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == sle_pkg::ACT_STORE |-> o_char_count != 8'd0)
        else $error("store left empty line");

    // terminal number is zero unless a switch is reported
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action != sle_pkg::ACT_TERM |-> o_terminal_select == 2'd0)
        else $error("terminal_select set without switch");

endmodule

bind scancode_line_editor_core sle_checker u_sle_checker (.*);
